// ===== hw/rtl/bmpdec_pkg.sv =====
// Shared types and constants for the bitmap stream pixel decoder.
package bmpdec_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 12;
    localparam int HEADER_END    = 54;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [2:0] KIND_PIXEL       = 3'd0;
    localparam logic [2:0] KIND_DONE        = 3'd1;
    localparam logic [2:0] KIND_BAD_SIG     = 3'd2;
    localparam logic [2:0] KIND_TRUNCATED   = 3'd3;
    localparam logic [2:0] KIND_UNSUPPORTED = 3'd4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } bmp_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
        logic [7:0]  channel_first;
        logic [7:0]  channel_second;
        logic [7:0]  channel_third;
        logic [7:0]  alpha;
        logic        final_result;
    } bmp_out_t;

    // Work handed from the header front end to the pixel back end.
    typedef struct packed {
        logic       is_status;
        logic [2:0] kind;
        logic       start_image;
        logic [7:0] byte_value;
        logic       end_of_file;
    } bmpdec_cmd_t;

    // Image geometry, stable while the back end runs pixels.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             bottom_up;
        logic             four_bytes;
        logic [1:0]       row_padding;
    } bmpdec_geom_t;

    function automatic logic [DIM_W-1:0] magnitude_sat(input logic [31:0] v);
        logic [31:0] m;
        begin
            m = v[31] ? (32'd0 - v) : v;
            if (m > 32'(MAX_DIMENSION))
                magnitude_sat = DIM_W'(MAX_DIMENSION + 1);
            else
                magnitude_sat = m[DIM_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/bmp_stream_pixel_decoder_top.sv =====
// Top level of the bitmap stream pixel decoder.
// The decoder takes one file byte per cycle unless stalled, header, skipped
// bytes and pixel data alike, and gives one result per pixel; the final status
// comes alone or with the last pixel. Results pass the command queue and the
// output register. A two-entry queue between the header parser and the pixel
// assembler takes one more byte when the output stalls; the input is then
// stalled from the next cycle through the cycle in which the output moves
// again. After the final status the block takes and drops bytes until reset.
module bmp_stream_pixel_decoder_top
    import bmpdec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  bmp_in_t  in_data,
    output logic     in_stall,
    output logic     out_valid,
    output bmp_out_t out_data,
    input  logic     out_stall
);

    logic         cmd_valid, q_full, q_ne, q_pop, back_done;
    bmpdec_cmd_t  cmd_data, q_head;
    bmpdec_geom_t geom;

    bmpdec_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(in_data),
        .in_stall(in_stall), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
        .cmd_full(q_full), .geom(geom), .back_done(back_done)
    );

    bmpdec_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(cmd_valid), .push_data(cmd_data),
        .full(q_full), .not_empty(q_ne), .head(q_head), .pop(q_pop)
    );

    bmpdec_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(q_pop),
        .geom(geom), .done(back_done), .out_valid(out_valid), .out_data(out_data),
        .out_stall(out_stall)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && cmd_valid && !q_pop))
        else $error("command queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.final_result |-> out_data.kind != KIND_PIXEL)
        else $error("final result flagged as plain pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(back_done) |-> back_done)
        else $error("done flag dropped");

endmodule

// ===== hw/rtl/bmpdec_front.sv =====
// Header parser: signature, fields, offset skip; forwards pixel bytes and status.
module bmpdec_front
    import bmpdec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  bmp_in_t      in_data,
    output logic         in_stall,
    output logic         cmd_valid,
    output bmpdec_cmd_t  cmd_data,
    input  logic         cmd_full,
    output bmpdec_geom_t geom,
    input  logic         back_done
);

    typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_DATA, PH_FINISHED} phase_t;

    phase_t       phase_reg, phase_next;
    logic [31:0]  pos_reg, pos_next;
    logic [31:0]  word_reg, word_next;
    logic [31:0]  start_reg, start_next;
    bmpdec_geom_t geom_reg, geom_next;
    logic         bpp_ok_reg, bpp_ok_next;
    logic [31:0]  w;
    logic [15:0]  depth;
    logic         take;
    logic [DIM_W+1:0] row_bytes;

    assign in_stall = cmd_full;
    assign take     = in_valid && !cmd_full;
    assign geom     = geom_reg;
    assign w        = {in_data.byte_value, word_reg[31:8]};
    assign depth    = w[31:16];

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        start_next = start_reg;
        geom_next  = geom_reg;
        bpp_ok_next = bpp_ok_reg;
        cmd_valid  = 1'b0;
        cmd_data   = '0;
        cmd_data.byte_value  = in_data.byte_value;
        cmd_data.end_of_file = in_data.end_of_file;
        row_bytes  = '0;
        if (back_done)
            phase_next = PH_FINISHED;
        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    pos_next  = pos_reg + 32'd1;
                    word_next = w;
                    if (pos_reg == 32'd13)
                        start_next = w;
                    if (pos_reg == 32'd21)
                        geom_next.width = magnitude_sat(w);
                    if (pos_reg == 32'd25)
                    begin
                        geom_next.height    = magnitude_sat(w);
                        geom_next.bottom_up = !w[31];
                    end
                    if (pos_reg == 32'd29)
                    begin
                        bpp_ok_next          = (depth == 16'd24) || (depth == 16'd32);
                        geom_next.four_bytes = (depth == 16'd32);
                    end
                    if (pos_reg == 32'd1 && w[31:16] != 16'h4D42)
                    begin
                        cmd_valid = 1'b1;
                        cmd_data.is_status = 1'b1;
                        cmd_data.kind = KIND_BAD_SIG;
                        phase_next = PH_FINISHED;
                    end
                    else if (pos_reg == 32'(HEADER_END - 1))
                    begin
                        row_bytes = (geom_reg.four_bytes ? {geom_reg.width, 2'b00}
                                     : {1'b0, geom_reg.width, 1'b0}
                                       + {2'b00, geom_reg.width});
                        geom_next.row_padding = 2'd0 - row_bytes[1:0];
                        if (!bpp_ok_reg || start_reg < 32'(HEADER_END)
                            || geom_reg.width > DIM_W'(MAX_DIMENSION)
                            || geom_reg.height > DIM_W'(MAX_DIMENSION))
                        begin
                            cmd_valid = 1'b1;
                            cmd_data.is_status = 1'b1;
                            cmd_data.kind = KIND_UNSUPPORTED;
                            phase_next = PH_FINISHED;
                        end
                        else if (geom_reg.width == '0 || geom_reg.height == '0)
                        begin
                            cmd_valid = 1'b1;
                            cmd_data.is_status = 1'b1;
                            cmd_data.kind = KIND_DONE;
                            phase_next = PH_FINISHED;
                        end
                        else if (in_data.end_of_file)
                        begin
                            cmd_valid = 1'b1;
                            cmd_data.is_status = 1'b1;
                            cmd_data.kind = KIND_TRUNCATED;
                            phase_next = PH_FINISHED;
                        end
                        else if (start_reg == 32'(HEADER_END))
                        begin
                            cmd_valid = 1'b1;
                            cmd_data.start_image = 1'b1;
                            phase_next = PH_DATA;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                    else if (in_data.end_of_file)
                    begin
                        cmd_valid = 1'b1;
                        cmd_data.is_status = 1'b1;
                        cmd_data.kind = KIND_TRUNCATED;
                        phase_next = PH_FINISHED;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_reg + 32'd1;
                    if (in_data.end_of_file)
                    begin
                        cmd_valid = 1'b1;
                        cmd_data.is_status = 1'b1;
                        cmd_data.kind = KIND_TRUNCATED;
                        phase_next = PH_FINISHED;
                    end
                    else if (pos_reg + 32'd1 == start_reg)
                    begin
                        cmd_valid = 1'b1;
                        cmd_data.start_image = 1'b1;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    // The back end decides pixel, done or truncation for every data byte.
                    cmd_valid = !back_done;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            word_reg   <= '0;
            start_reg  <= '0;
            geom_reg   <= '0;
            bpp_ok_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            word_reg   <= word_next;
            start_reg  <= start_next;
            geom_reg   <= geom_next;
            bpp_ok_reg <= bpp_ok_next;
        end
    end

endmodule

// ===== hw/rtl/bmpdec_queue.sv =====
// Short queue between the front end and the back end.
module bmpdec_queue
    import bmpdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bmpdec_cmd_t push_data,
    output logic        full,
    output logic        not_empty,
    output bmpdec_cmd_t head,
    input  logic        pop
);

    bmpdec_cmd_t mem [QUEUE_DEPTH];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;

    assign full      = (cnt_reg == 2'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hw/rtl/bmpdec_back.sv =====
// Pixel assembler: packs bytes, tracks row and column, skips padding, emits results.
module bmpdec_back
    import bmpdec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  bmpdec_cmd_t  cmd,
    output logic         cmd_pop,
    input  bmpdec_geom_t geom,
    output logic         done,
    output logic         out_valid,
    output bmp_out_t     out_data,
    input  logic         out_stall
);

    logic [15:0]        bytes_reg, bytes_next;
    logic [1:0]         bip_reg, bip_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] rowc_reg, rowc_next;
    logic [1:0]         pad_reg, pad_next;
    logic               done_reg, done_next;
    logic               ov_reg, ov_next;
    bmp_out_t           od_reg, od_next;
    logic [1:0]         last_idx;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic [DIM_W-1:0]   row_flip;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign done      = done_reg;
    // Output register frees whenever taken; the head is consumed if it can be placed.
    assign cmd_pop   = cmd_valid && (!ov_reg || !out_stall);
    assign last_idx  = geom.four_bytes ? 2'd3 : 2'd2;
    assign col_inc   = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc   = {1'b0, rowc_reg} + DIM_W'(1);
    assign row_flip  = geom.height - DIM_W'(1) - {1'b0, rowc_reg};

    always_comb
    begin
        bytes_next = bytes_reg;
        bip_next   = bip_reg;
        col_next   = col_reg;
        rowc_next  = rowc_reg;
        pad_next   = pad_reg;
        done_next  = done_reg;
        ov_next    = ov_reg && out_stall;
        od_next    = od_reg;
        if (cmd_pop)
        begin
            if (cmd.is_status)
            begin
                ov_next = 1'b1;
                od_next = '0;
                od_next.kind = cmd.kind;
                od_next.final_result = 1'b1;
            end
            else if (cmd.start_image)
            begin
                bytes_next = '0;
                bip_next   = '0;
                col_next   = '0;
                rowc_next  = '0;
                pad_next   = '0;
            end
            else if (!done_reg)
            begin
                if (pad_reg != 2'd0)
                begin
                    pad_next = pad_reg - 2'd1;
                    if (cmd.end_of_file)
                    begin
                        ov_next = 1'b1;
                        od_next = '0;
                        od_next.kind = KIND_TRUNCATED;
                        od_next.final_result = 1'b1;
                        done_next = 1'b1;
                    end
                end
                else if (bip_reg != last_idx)
                begin
                    if (bip_reg == 2'd0)
                        bytes_next[7:0] = cmd.byte_value;
                    else if (bip_reg == 2'd1)
                        bytes_next[15:8] = cmd.byte_value;
                    if (bip_reg == 2'd2)
                        od_next.channel_third = cmd.byte_value;
                    bip_next = bip_reg + 2'd1;
                    if (cmd.end_of_file)
                    begin
                        ov_next = 1'b1;
                        od_next = '0;
                        od_next.kind = KIND_TRUNCATED;
                        od_next.final_result = 1'b1;
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    bip_next = '0;
                    bytes_next = '0;
                    ov_next = 1'b1;
                    od_next.pixel_column   = col_reg;
                    od_next.pixel_row      = geom.bottom_up ? row_flip[COORD_W-1:0]
                                                            : rowc_reg;
                    od_next.channel_first  = bytes_reg[7:0];
                    od_next.channel_second = bytes_reg[15:8];
                    if (geom.four_bytes)
                    begin
                        // Third byte was parked in the output register already.
                        od_next.channel_third = od_reg.channel_third;
                        od_next.alpha = cmd.byte_value;
                    end
                    else
                    begin
                        od_next.channel_third = cmd.byte_value;
                        od_next.alpha = 8'd255;
                    end
                    od_next.kind = KIND_PIXEL;
                    od_next.final_result = 1'b0;
                    col_next = col_inc[COORD_W-1:0];
                    if (col_inc >= geom.width)
                    begin
                        col_next  = '0;
                        rowc_next = row_inc[COORD_W-1:0];
                        pad_next  = geom.row_padding;
                        if (row_inc >= geom.height)
                        begin
                            od_next.kind = KIND_DONE;
                            od_next.final_result = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    if (cmd.end_of_file && !done_next)
                    begin
                        od_next = '0;
                        od_next.kind = KIND_TRUNCATED;
                        od_next.final_result = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            bip_reg   <= '0;
            col_reg   <= '0;
            rowc_reg  <= '0;
            pad_reg   <= '0;
            done_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            bip_reg   <= bip_next;
            col_reg   <= col_next;
            rowc_reg  <= rowc_next;
            pad_reg   <= pad_next;
            done_reg  <= done_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

endmodule
